>>> src/pin_change_capture_timer_macros.svh
// assertion macros for the pin change capture timer
`ifndef PIN_CHANGE_CAPTURE_TIMER_MACROS_SVH
`define PIN_CHANGE_CAPTURE_TIMER_MACROS_SVH

// same-cycle implication, disabled during reset
`define PCCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PCCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/pcct_pkg.sv
// types, constants and codes of the pin change capture timer
package pcct_pkg;

  localparam int unsigned LEVEL_W    = 20;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned PIN_IDX_W  = 5;
  localparam int unsigned DEB_W      = 16;
  localparam int unsigned WIDTH_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned PIN_COUNT_DEF = 20;

  localparam logic [WIDTH_W-1:0] RC_MIN = 16'd900;
  localparam logic [WIDTH_W-1:0] RC_MAX = 16'd2100;

  typedef enum logic [2:0] {
    MODE_RC      = 3'd0,
    MODE_RAW     = 3'd1,
    MODE_SWITCH  = 3'd2,
    MODE_PERIOD  = 3'd3,
    MODE_TACH    = 3'd4,
    MODE_ENCODER = 3'd5
  } pcct_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WATCH_MASK  = 3'd0,
    REG_MODE        = 3'd1,
    REG_MEASURE_PIN = 3'd2,
    REG_DATA_PIN    = 3'd3,
    REG_RISING_EDGE = 3'd4,
    REG_HALF_STEP   = 3'd5,
    REG_DEBOUNCE    = 3'd6
  } pcct_reg_e;

  typedef struct packed {
    logic [TIME_W-1:0]  sample_time;
    logic [LEVEL_W-1:0] pin_levels;
  } pcct_in_t;

  typedef struct packed {
    logic [TIME_W-1:0]        event_time;
    logic [LEVEL_W-1:0]       changed_pins;
    logic [LEVEL_W-1:0]       levels_out;
    logic signed [TIME_W-1:0] measurement;
    logic                     measure_valid;
    logic [TIME_W-1:0]        event_count;
  } pcct_out_t;

  typedef struct packed {
    logic [2:0]           mode;
    logic [PIN_IDX_W-1:0] measure_pin;
    logic [PIN_IDX_W-1:0] data_pin;
    logic                 rising_edge;
    logic                 half_step;
    logic [DEB_W-1:0]     debounce_ticks;
  } pcct_cfg_t;

  typedef struct packed {
    logic              update;
    logic [TIME_W-1:0] value;
  } pcct_edge_t;

endpackage

>>> src/pcct_chan_if.sv
// valid/ready channel carrying one item of payload type T
interface pcct_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> src/pcct_measure.sv
// per-event measurement of the configured channel and edge timestamp update
module pcct_measure (
  input  pcct_pkg::pcct_cfg_t                 cfg_i,
  input  logic [pcct_pkg::TIME_W-1:0]         edge_time_i,
  input  logic [pcct_pkg::TIME_W-1:0]         sample_time_i,
  input  logic [pcct_pkg::LEVEL_W-1:0]        levels_i,
  input  logic [pcct_pkg::LEVEL_W-1:0]        changed_i,
  output logic signed [pcct_pkg::TIME_W-1:0]  measurement_o,
  output logic                                measure_valid_o,
  output pcct_pkg::pcct_edge_t                edge_o
);
  import pcct_pkg::*;

  localparam int unsigned PAD_W = (1 << PIN_IDX_W) - LEVEL_W;

  logic [(1 << PIN_IDX_W)-1:0] lv_ext;
  logic [(1 << PIN_IDX_W)-1:0] ch_ext;
  logic                        lvl;
  logic                        dat;
  logic                        valid;
  logic [TIME_W-1:0]           d;
  logic [WIDTH_W-1:0]          w;
  logic [TIME_W-1:0]           m;
  logic                        upd;

  // pins past the level field read as low and never as changed
  assign lv_ext = {{PAD_W{1'b0}}, levels_i};
  assign ch_ext = {{PAD_W{1'b0}}, changed_i};
  assign lvl    = lv_ext[cfg_i.measure_pin];
  assign dat    = lv_ext[cfg_i.data_pin];
  assign valid  = ch_ext[cfg_i.measure_pin];
  assign d      = sample_time_i - edge_time_i;
  assign w      = d[WIDTH_W-1:0];

  always_comb begin
    m   = '0;
    upd = 1'b0;
    case (cfg_i.mode)
      MODE_RC, MODE_RAW: begin
        if (lvl) begin
          upd = 1'b1;
        end else if (cfg_i.mode == MODE_RAW || (w > RC_MIN && w < RC_MAX)) begin
          m = {{(TIME_W-WIDTH_W){1'b0}}, w};
        end
      end
      MODE_SWITCH: begin
        if (d >= {{(TIME_W-DEB_W){1'b0}}, cfg_i.debounce_ticks}) begin
          upd = 1'b1;
          m   = {{(TIME_W-1){1'b0}}, lvl == cfg_i.rising_edge};
        end
      end
      MODE_PERIOD: begin
        if (lvl == cfg_i.rising_edge) begin
          upd = 1'b1;
          m   = {{(TIME_W-WIDTH_W){1'b0}}, w};
        end
      end
      MODE_TACH: begin
        if (lvl) begin
          upd = 1'b1;
          m   = dat ? d : (~d + 1'b1);
        end
      end
      MODE_ENCODER: begin
        // clock high steps down with data high, clock low steps the other way in half-step mode
        if (lvl) begin
          m = dat ? '1 : TIME_W'(1);
        end else if (cfg_i.half_step) begin
          m = dat ? TIME_W'(1) : '1;
        end
      end
      default: begin
        m   = '0;
        upd = 1'b0;
      end
    endcase
  end

  assign measurement_o   = valid ? signed'(m) : '0;
  assign measure_valid_o = valid;
  assign edge_o.update   = valid & upd;
  assign edge_o.value    = sample_time_i;

endmodule

>>> src/pin_change_capture_timer.sv
// pin change capture timer: top level with input stage, event logic and result register
//
// Items on in_i carry a sample time and the pin levels. An item whose watched
// pins match the levels of the last event gives no result and leaves all state
// as it was. Any other item is an event: it is counted, its levels are stored
// and one item leaves on res_o with time, changed pins, levels, the channel
// measurement and the running event count.
// From acceptance on in_i an item sits in the input register, then the event logic
// (one 32-bit subtract and compare) feeds the result register, which drives res_o.
// One item is accepted every cycle unless an event waits for a full result register.
// When res_o stalls, the held result keeps res_o, the input register takes one
// more item, and in_i ready falls only when that item is an event and would
// need the occupied result register; items without an event still drain.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i by the user only
// while the block is idle (not enforced); indexes past the register list are ignored.
// Reset clears the stored levels, the edge time, the event count and the
// registers to their defaults (rising_edge set, all others zero).
module pin_change_capture_timer #(
  parameter int unsigned PIN_COUNT = pcct_pkg::PIN_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  pcct_chan_if.sink                        in_i,
  pcct_chan_if.source                      res_o,
  input  logic                             cfg_we_i,
  input  logic [pcct_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pcct_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import pcct_pkg::*;

  `include "pin_change_capture_timer_macros.svh"

  logic [LEVEL_W-1:0] watch_mask_q;
  pcct_cfg_t          cfg_q;

  logic               s1_valid_q;
  pcct_in_t           s1_q;
  logic               res_valid_q;
  pcct_out_t          res_q;
  pcct_out_t          res_d;

  logic [LEVEL_W-1:0] last_levels_q;
  logic [TIME_W-1:0]  edge_time_q;
  logic [TIME_W-1:0]  event_total_q;
  logic [TIME_W-1:0]  event_total_d;

  logic [LEVEL_W-1:0] pin_mask;
  logic [LEVEL_W-1:0] levels;
  logic [LEVEL_W-1:0] changed;
  logic               is_event;
  logic               out_free;
  logic               s1_go;
  logic               in_acc;
  logic               emit;

  logic signed [TIME_W-1:0] meas;
  logic                     meas_valid;
  pcct_edge_t               edge_upd;

  always_comb begin
    for (int n = 0; n < LEVEL_W; n++) begin
      pin_mask[n] = (n < PIN_COUNT);
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watch_mask_q         <= '0;
      cfg_q.mode           <= MODE_RC;
      cfg_q.measure_pin    <= '0;
      cfg_q.data_pin       <= '0;
      cfg_q.rising_edge    <= 1'b1;
      cfg_q.half_step      <= 1'b0;
      cfg_q.debounce_ticks <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WATCH_MASK:  watch_mask_q         <= cfg_data_i[LEVEL_W-1:0];
        REG_MODE:        cfg_q.mode           <= cfg_data_i[2:0];
        REG_MEASURE_PIN: cfg_q.measure_pin    <= cfg_data_i[PIN_IDX_W-1:0];
        REG_DATA_PIN:    cfg_q.data_pin       <= cfg_data_i[PIN_IDX_W-1:0];
        REG_RISING_EDGE: cfg_q.rising_edge    <= cfg_data_i[0];
        REG_HALF_STEP:   cfg_q.half_step      <= cfg_data_i[0];
        REG_DEBOUNCE:    cfg_q.debounce_ticks <= cfg_data_i[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  // event detection on the registered item
  assign levels   = s1_q.pin_levels & pin_mask;
  assign changed  = (levels ^ last_levels_q) & watch_mask_q;
  assign is_event = |changed;

  assign out_free    = !res_valid_q || res_o.ready;
  assign s1_go       = s1_valid_q && (!is_event || out_free);
  assign emit        = s1_go && is_event;
  assign in_i.ready  = !s1_valid_q || s1_go;
  assign in_acc      = in_i.valid && in_i.ready;

  pcct_measure u_measure (
    .cfg_i           (cfg_q),
    .edge_time_i     (edge_time_q),
    .sample_time_i   (s1_q.sample_time),
    .levels_i        (levels),
    .changed_i       (changed),
    .measurement_o   (meas),
    .measure_valid_o (meas_valid),
    .edge_o          (edge_upd)
  );

  assign event_total_d = event_total_q + 1'b1;

  always_comb begin
    res_d.event_time    = s1_q.sample_time;
    res_d.changed_pins  = changed;
    res_d.levels_out    = levels;
    res_d.measurement   = meas;
    res_d.measure_valid = meas_valid;
    res_d.event_count   = event_total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      res_valid_q   <= 1'b0;
      last_levels_q <= '0;
      edge_time_q   <= '0;
      event_total_q <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (emit) begin
        res_valid_q   <= 1'b1;
        last_levels_q <= levels;
        event_total_q <= event_total_d;
        if (edge_upd.update) begin
          edge_time_q <= edge_upd.value;
        end
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_i.payload;
    end
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

  `PCCT_ASSERT_NXT(a_count_step, emit, event_total_q == $past(event_total_q) + 1'b1,
                   "event count did not advance on an event")
  `PCCT_ASSERT_NXT(a_levels_hold, !emit, $stable(last_levels_q) && $stable(event_total_q),
                   "state changed without an event")
  `PCCT_ASSERT_IMP(a_result_changed, res_valid_q, res_q.changed_pins != '0,
                   "result item without changed pins")
  `PCCT_ASSERT_IMP(a_no_lost_event, s1_valid_q && is_event && !out_free, !in_i.ready,
                   "input accepted while an event is blocked")

endmodule

>>> bench/tb_top.sv
// testbench for the pin change capture timer: directed and random items checked against a predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pcct_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE   = 3'd7;
  localparam logic [2:0]           MODE_SPARE = 3'd7;
  localparam int unsigned DRAIN_CYCLES     = 4;
  localparam int unsigned HOLD_CYCLES      = 80;
  localparam int unsigned RAND_PHASES      = 14;
  localparam int unsigned EVENTS_PER_PHASE = 57;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pcct_chan_if #(.T(pcct_in_t))  in_if ();
  pcct_chan_if #(.T(pcct_out_t)) res_if ();

  logic                  drv_valid = 1'b0;
  pcct_in_t              drv_item  = '0;
  logic                  rcv_ready = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  assign in_if.valid   = drv_valid;
  assign in_if.payload = drv_item;
  assign res_if.ready  = rcv_ready;

  pin_change_capture_timer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // configuration and state as the block should hold them
  logic [LEVEL_W-1:0]   watch_mask_q   = '0;
  logic [2:0]           mode_q         = MODE_RC;
  logic [PIN_IDX_W-1:0] measure_pin_q  = '0;
  logic [PIN_IDX_W-1:0] data_pin_q     = '0;
  logic                 rising_q       = 1'b1;
  logic                 half_step_q    = 1'b0;
  logic [DEB_W-1:0]     debounce_q     = '0;
  logic [LEVEL_W-1:0]   last_levels_q  = '0;
  logic [TIME_W-1:0]    edge_time_q    = '0;
  logic [TIME_W-1:0]    event_total_q  = '0;

  pcct_in_t  pending_items[$];
  pcct_out_t expected_events[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req_cnt   = 0;
  int unsigned errors         = 0;
  int unsigned n_sent         = 0;
  int unsigned n_checked      = 0;
  int unsigned n_phases       = 0;

  // stimulus generator state
  logic [TIME_W-1:0]  gen_time   = '0;
  logic [LEVEL_W-1:0] gen_levels = '0;
  logic [LEVEL_W-1:0] gen_last   = '0;

  function automatic logic pin_at(logic [LEVEL_W-1:0] v, logic [PIN_IDX_W-1:0] pin);
    if (pin >= PIN_COUNT_DEF) return 1'b0;
    return v[pin];
  endfunction

  function automatic logic [TIME_W-1:0] channel_measure(logic [TIME_W-1:0] t,
                                                         logic [LEVEL_W-1:0] lv);
    logic               lvl;
    logic               dat;
    logic [TIME_W-1:0]  d;
    logic [WIDTH_W-1:0] w;
    lvl = pin_at(lv, measure_pin_q);
    dat = pin_at(lv, data_pin_q);
    d   = t - edge_time_q;
    w   = d[WIDTH_W-1:0];
    case (mode_q)
      MODE_RC, MODE_RAW: begin
        if (lvl) begin
          edge_time_q = t;
          return '0;
        end
        if (mode_q == MODE_RC && !(w > RC_MIN && w < RC_MAX)) return '0;
        return TIME_W'(w);
      end
      MODE_SWITCH: begin
        if (d >= TIME_W'(debounce_q)) begin
          edge_time_q = t;
          return TIME_W'(lvl == rising_q);
        end
        return '0;
      end
      MODE_PERIOD: begin
        if (lvl == rising_q) begin
          edge_time_q = t;
          return TIME_W'(w);
        end
        return '0;
      end
      MODE_TACH: begin
        if (lvl) begin
          edge_time_q = t;
          return dat ? d : -d;
        end
        return '0;
      end
      MODE_ENCODER: begin
        if (lvl) return dat ? '1 : TIME_W'(1);
        if (half_step_q) return dat ? TIME_W'(1) : '1;
        return '0;
      end
      default: return '0;
    endcase
  endfunction

  function automatic void predict_event(pcct_in_t it);
    logic [LEVEL_W-1:0] changed;
    pcct_out_t          r;
    changed = (it.pin_levels ^ last_levels_q) & watch_mask_q;
    if (changed == '0) return;
    r.event_time    = it.sample_time;
    r.changed_pins  = changed;
    r.levels_out    = it.pin_levels;
    r.measure_valid = pin_at(changed, measure_pin_q);
    r.measurement   = '0;
    if (r.measure_valid) r.measurement = channel_measure(it.sample_time, it.pin_levels);
    event_total_q   = event_total_q + 1;
    r.event_count   = event_total_q;
    last_levels_q   = it.pin_levels;
    expected_events.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (actv !== expv) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expv, actv);
    end
  endfunction

  // random bits above the register field, which the block must drop
  function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] v,
                                                      int unsigned w);
    logic [CFG_DATA_W-1:0] keep;
    keep = CFG_DATA_W'((CFG_DATA_W'(1) << w) - 1);
    return (CFG_DATA_W'($urandom) & ~keep) | (v & keep);
  endfunction

  function automatic pcct_in_t gen_item();
    logic [LEVEL_W-1:0] lv;
    int unsigned        pick;
    pcct_in_t           it;
    lv   = gen_levels;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      if (measure_pin_q < PIN_COUNT_DEF) lv[measure_pin_q] = ~lv[measure_pin_q];
      else lv = lv ^ (LEVEL_W'(1) << $urandom_range(0, LEVEL_W - 1));
      if (data_pin_q < PIN_COUNT_DEF && $urandom_range(0, 1) == 1)
        lv[data_pin_q] = ~lv[data_pin_q];
    end else if (pick < 75) begin
      lv = lv ^ (LEVEL_W'(1) << $urandom_range(0, LEVEL_W - 1))
              ^ (LEVEL_W'(1) << $urandom_range(0, LEVEL_W - 1));
    end else if (pick >= 85) begin
      lv = LEVEL_W'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 40)      gen_time = gen_time + $urandom_range(0, 2500);
    else if (pick < 60) gen_time = gen_time + $urandom_range(RC_MIN - 50, RC_MAX + 50);
    else if (pick < 80) gen_time = gen_time + $urandom_range(0, 100);
    else if (pick < 92) gen_time = gen_time + $urandom_range(0, 1 << 17);
    else                gen_time = $urandom;
    gen_levels     = lv;
    it.sample_time = gen_time;
    it.pin_levels  = lv;
    return it;
  endfunction

  task automatic send(logic [TIME_W-1:0] t, logic [LEVEL_W-1:0] lv);
    pcct_in_t it;
    it.sample_time = t;
    it.pin_levels  = lv;
    pending_items.push_back(it);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      REG_WATCH_MASK:  watch_mask_q  = val[LEVEL_W-1:0];
      REG_MODE:        mode_q        = val[2:0];
      REG_MEASURE_PIN: measure_pin_q = val[PIN_IDX_W-1:0];
      REG_DATA_PIN:    data_pin_q    = val[PIN_IDX_W-1:0];
      REG_RISING_EDGE: rising_q      = val[0];
      REG_HALF_STEP:   half_step_q   = val[0];
      REG_DEBOUNCE:    debounce_q    = val[DEB_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // items without an event may still be inside the block, hence the extra cycles
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || drv_valid || expected_events.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : drive
    logic next_valid;
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_if.ready) begin
        predict_event(drv_item);
        n_sent++;
      end
      if (!drv_valid || in_if.ready) begin
        next_valid = pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
        if (next_valid) drv_item <= pending_items.pop_front();
        drv_valid <= next_valid;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    pcct_out_t   exp_r;
    int unsigned hold_seen;
    int unsigned hold_left;
    if (!rst_ni) begin
      rcv_ready <= 1'b0;
      hold_seen = hold_req_cnt;
      hold_left = 0;
    end else begin
      if (res_if.valid && rcv_ready) begin
        if (expected_events.size() == 0) begin
          errors++;
          $display("%0t: result item with none expected, actual %p", $time, res_if.payload);
        end else begin
          exp_r = expected_events.pop_front();
          check_field("event_time", exp_r.event_time, res_if.payload.event_time);
          check_field("changed_pins", 32'(exp_r.changed_pins),
                      32'(res_if.payload.changed_pins));
          check_field("levels_out", 32'(exp_r.levels_out), 32'(res_if.payload.levels_out));
          check_field("measurement", exp_r.measurement, res_if.payload.measurement);
          check_field("measure_valid", 32'(exp_r.measure_valid),
                      32'(res_if.payload.measure_valid));
          check_field("event_count", exp_r.event_count, res_if.payload.event_count);
          n_checked++;
        end
      end
      if (hold_seen != hold_req_cnt) begin
        hold_seen = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rcv_ready <= 1'b0;
      end else begin
        rcv_ready <= $urandom_range(0, 99) >= recv_stall_pct;
      end
    end
  end

  initial begin
    int unsigned          p;
    int unsigned          events;
    int unsigned          tries;
    logic [PIN_IDX_W-1:0] mp;
    logic [PIN_IDX_W-1:0] dp;
    logic [LEVEL_W-1:0]   mask;
    logic [2:0]           md;
    logic                 paused;
    pcct_in_t             it;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle_pct  = 34;
    recv_stall_pct = 51;

    // nothing is watched after reset
    send(32'h0, '1);
    wait_idle();

    write_reg(REG_WATCH_MASK, '1);
    write_reg(REG_NONE, '1);
    write_reg(REG_MODE, {17'h1FFFF, MODE_RC});
    send(32'hFFFF_FF00, '1);
    send(32'h0000_0284, 20'hFFFFE);   // width of 900 across the time wrap, filtered
    send(32'h0000_0300, '1);
    send(32'h0000_0B33, 20'hFFFFE);   // width 2099
    send(32'h0000_0B33, 20'hFFFFE);   // levels unchanged
    send(32'h0000_1000, '1);
    send(32'h0000_1834, 20'hFFFFE);   // width 2100, filtered
    wait_idle();

    write_reg(REG_MODE, CFG_DATA_W'(MODE_RAW));
    send(32'h0001_0000, '1);
    send(32'h0002_2345, 20'hFFFFE);   // width truncated to 16 bits
    wait_idle();

    write_reg(REG_MODE, CFG_DATA_W'(MODE_SWITCH));
    write_reg(REG_DEBOUNCE, 20'hFFFF);
    write_reg(REG_RISING_EDGE, CFG_DATA_W'(1'b0));
    write_reg(REG_MEASURE_PIN, CFG_DATA_W'(5'd19));
    send(32'h0003_0000, 20'h7FFFE);
    send(32'h0003_000A, 20'hFFFFE);   // bounce inside the debounce window
    send(32'h0004_0009, 20'h7FFFE);   // exactly the debounce time later
    wait_idle();

    write_reg(REG_MODE, CFG_DATA_W'(MODE_PERIOD));
    write_reg(REG_RISING_EDGE, CFG_DATA_W'(1'b1));
    send(32'h0004_1000, 20'hFFFFE);
    send(32'h0004_2000, 20'h7FFFE);
    wait_idle();

    write_reg(REG_MODE, CFG_DATA_W'(MODE_TACH));
    write_reg(REG_MEASURE_PIN, CFG_DATA_W'(5'd0));
    write_reg(REG_DATA_PIN, CFG_DATA_W'(5'd19));
    send(32'h0005_0000, 20'hFFFFF);
    send(32'h0005_0100, 20'hFFFFE);
    send(32'h0005_0400, 20'h7FFFF);   // direction low gives a negative period
    wait_idle();

    write_reg(REG_MODE, CFG_DATA_W'(MODE_ENCODER));
    write_reg(REG_HALF_STEP, CFG_DATA_W'(1'b1));
    send(32'h0006_0000, 20'h7FFFE);
    send(32'h0006_0010, 20'hFFFFF);
    send(32'h0006_0020, 20'hFFFFE);
    send(32'h0006_0030, 20'h7FFFF);
    wait_idle();

    write_reg(REG_MODE, CFG_DATA_W'(MODE_SPARE));
    send(32'h0007_0000, 20'h7FFFE);
    wait_idle();
    // measured pin past the pin count never reports a measurement
    write_reg(REG_MEASURE_PIN, CFG_DATA_W'(5'd31));
    write_reg(REG_MODE, CFG_DATA_W'(MODE_TACH));
    send(32'h0007_0100, 20'h00000);
    wait_idle();

    gen_time   = $urandom;
    gen_levels = last_levels_q;
    for (p = 0; p < RAND_PHASES; p++) begin
      if (p < 5) begin
        send_idle_pct  = 34;
        recv_stall_pct = 51;
      end else if (p < 10) begin
        send_idle_pct  = 51;
        recv_stall_pct = 34;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      mp = (p == 3) ? 5'd0 : (p == 5) ? 5'd19 : (p == 9) ? 5'd31
         : PIN_IDX_W'($urandom_range(0, 19));
      dp = (p == 9) ? 5'd25 : PIN_IDX_W'($urandom_range(0, 19));
      mask = (p % 4 == 0) ? '1 : LEVEL_W'($urandom);
      if (p % 4 != 3 && mp < PIN_COUNT_DEF) mask[mp] = 1'b1;
      md = p[2:0];
      write_reg(REG_WATCH_MASK, mask);
      write_reg(REG_MODE, with_junk(CFG_DATA_W'(md), 3));
      write_reg(REG_MEASURE_PIN, with_junk(CFG_DATA_W'(mp), PIN_IDX_W));
      write_reg(REG_DATA_PIN, with_junk(CFG_DATA_W'(dp), PIN_IDX_W));
      write_reg(REG_RISING_EDGE, with_junk(CFG_DATA_W'($urandom_range(0, 1)), 1));
      write_reg(REG_HALF_STEP, with_junk(CFG_DATA_W'(p % 2), 1));
      write_reg(REG_DEBOUNCE, with_junk(CFG_DATA_W'((p % 3 == 0) ? 0 : (p % 3 == 1) ? 16'hFFFF
                                        : $urandom_range(0, 4000)), DEB_W));
      n_phases++;
      if (p == 10) hold_req_cnt++;   // long receiver hold while items keep coming
      gen_last = last_levels_q;
      events   = 0;
      tries    = 0;
      paused   = 1'b0;
      while (events < EVENTS_PER_PHASE && tries < EVENTS_PER_PHASE * 10) begin
        if (p == 6 && !paused && events == EVENTS_PER_PHASE / 2) begin
          paused = 1'b1;
          wait_idle();
        end
        it = gen_item();
        pending_items.push_back(it);
        if (((it.pin_levels ^ gen_last) & watch_mask_q) != '0) begin
          events++;
          gen_last = it.pin_levels;
        end
        tries++;
      end
      wait_idle();
    end

    $display("tb_top: %0d items accepted, %0d result items checked, %0d mismatches",
             n_sent, n_checked, errors);
    $display("tb_top: %0d random settings over all eight modes, plus directed edge cases",
             n_phases);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/pcct_pkg.sv
src/pcct_chan_if.sv
src/pcct_measure.sv
src/pin_change_capture_timer.sv
bench/tb_top.sv
